### design/cfd_pkg.sv
// shared types and constants of the checked frame deframer
// used by cfd_ctrl, cfd_dpath and checked_frame_deframer; no dependencies
package cfd_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int MIN_FRAME   = 6;                  // header, address, id, length, two checks
   localparam int PAY_OFFSET  = 4;                  // first payload byte within a frame
   localparam int STORE_DEPTH = MAX_PAYLOAD + MIN_FRAME;
   localparam int PTR_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int LEN_W       = 6;
   localparam int IDX_W       = 5;
   localparam int BYTE_W      = 8;
   localparam int RSP_FIELD_W = BYTE_W + LEN_W + BYTE_W + IDX_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int CSR_IDX_W   = 1;

   typedef logic [PTR_W-1:0]     ptr_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_HEADER_BYTE   = csr_idx_type'(0);
   localparam csr_idx_type CSR_MATCH_ADDRESS = csr_idx_type'(1);

   localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'hFF;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL_CK,
      S_HUNT_RD,
      S_HUNT_CK,
      S_ADDR_CK,
      S_ID_CK,
      S_LEN_CK,
      S_SUM,
      S_SUM_CK,
      S_ADD_CK,
      S_MARK,
      S_EMIT
   } state_type;

   // which stored byte, relative to the front, the store read fetches
   typedef enum logic [3:0] {
      RD_FRONT,
      RD_ADDR,
      RD_ID,
      RD_LEN,
      RD_PAY0,
      RD_SUM_NEXT,
      RD_PAY_NEXT,
      RD_SUM_CHK,
      RD_ADD_CHK
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       drop_one;
      logic       drop_frame;
      logic       front_mark;
      logic       id_load;
      logic       len_load;
      logic       acc_clear;
      logic       acc_en;
      logic       cnt_clear;
      logic       cnt_inc;
      logic       out_pay;
      logic       out_mark;
   } cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic fill_short;
      logic fill_full;
      logic front_valid;
      logic is_header;
      logic addr_ok;
      logic len_ok;
      logic short_rd;
      logic short_len;
      logic sum_done;
      logic sum_ok;
      logic add_ok;
      logic len_zero;
      logic pay_last;
      logic out_free;
   } sts_type;

endpackage

### design/cfd_ctrl.sv
// controller state machine of the checked frame deframer
// depends on cfd_pkg; drives the command struct of cfd_dpath
module cfd_ctrl import cfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.rd_sel = RD_FRONT;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               // a validated front with known length only needs a fill compare
               state_in = (sts.front_valid && !sts.fill_full) ? S_FILL_CK : S_HUNT_RD;
            end
         end
         S_FILL_CK: begin
            if (sts.short_len) begin
               state_in = S_IDLE;
            end else begin
               cmd.acc_clear = 1'b1;
               cmd.cnt_clear = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_FRONT;
               state_in      = S_SUM;
            end
         end
         S_HUNT_RD: begin
            if (sts.fill_zero) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_FRONT;
               state_in   = S_HUNT_CK;
            end
         end
         S_HUNT_CK: begin
            if (!sts.is_header) begin
               cmd.drop_one = 1'b1;
               state_in     = S_HUNT_RD;
            end else if (sts.fill_short) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ADDR;
               state_in   = S_ADDR_CK;
            end
         end
         S_ADDR_CK: begin
            if (!sts.addr_ok) begin
               cmd.drop_one = 1'b1;
               state_in     = S_HUNT_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ID;
               state_in   = S_ID_CK;
            end
         end
         S_ID_CK: begin
            cmd.id_load = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_LEN;
            state_in    = S_LEN_CK;
         end
         S_LEN_CK: begin
            if (!sts.len_ok) begin
               cmd.drop_one = 1'b1;
               state_in     = S_HUNT_RD;
            end else if (sts.short_rd) begin
               cmd.len_load   = 1'b1;
               cmd.front_mark = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.len_load  = 1'b1;
               cmd.acc_clear = 1'b1;
               cmd.cnt_clear = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_FRONT;
               state_in      = S_SUM;
            end
         end
         S_SUM: begin
            cmd.acc_en = 1'b1;
            cmd.rd_en  = 1'b1;
            if (sts.sum_done) begin
               cmd.rd_sel = RD_SUM_CHK;
               state_in   = S_SUM_CK;
            end else begin
               cmd.rd_sel  = RD_SUM_NEXT;
               cmd.cnt_inc = 1'b1;
            end
         end
         S_SUM_CK: begin
            if (!sts.sum_ok) begin
               cmd.drop_one = 1'b1;
               state_in     = S_HUNT_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ADD_CHK;
               state_in   = S_ADD_CK;
            end
         end
         S_ADD_CK: begin
            if (!sts.add_ok) begin
               cmd.drop_one = 1'b1;
               state_in     = S_HUNT_RD;
            end else if (sts.len_zero) begin
               state_in = S_MARK;
            end else begin
               cmd.cnt_clear = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_PAY0;
               state_in      = S_EMIT;
            end
         end
         S_MARK: begin
            if (sts.out_free) begin
               cmd.out_mark   = 1'b1;
               cmd.drop_frame = 1'b1;
               state_in       = S_HUNT_RD;
            end
         end
         S_EMIT: begin
            // read data holds while the output register is still occupied
            if (sts.out_free) begin
               cmd.out_pay = 1'b1;
               if (sts.pay_last) begin
                  cmd.drop_frame = 1'b1;
                  state_in       = S_HUNT_RD;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = RD_PAY_NEXT;
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### design/cfd_dpath.sv
// datapath of the checked frame deframer: circular byte store, check sums,
// frame fields and the result register; depends on cfd_pkg
module cfd_dpath import cfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              csr_write,
   input  csr_idx_type       csr_index,
   input  logic [BYTE_W-1:0] csr_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] frame_id,
   output logic [LEN_W-1:0]  payload_length,
   output logic [BYTE_W-1:0] payload_byte,
   output logic [IDX_W-1:0]  byte_index,
   output logic              last
);

   logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [BYTE_W-1:0] header_ff, address_ff;
   ptr_type           head_ff, head_in;
   cnt_type           fill_ff, fill_in;
   logic              front_valid_ff, front_valid_in;
   cnt_type           len_ff, cnt_ff;
   logic [BYTE_W-1:0] id_ff;
   logic [BYTE_W-1:0] running_sum_ff, running_add_ff, running_sum_in;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] frame_id_ff, payload_byte_ff;
   logic [LEN_W-1:0]  payload_length_ff;
   logic [IDX_W-1:0]  byte_index_ff;
   logic              last_ff;

   cnt_type           rd_off, drop_cnt;
   ptr_type           rd_addr, wr_addr;
   logic              full;

   // base plus offset around the store; offset never exceeds the depth so one fold suffices
   function automatic ptr_type wrap(input ptr_type base, input cnt_type off);
      logic [CNT_W:0] sum;
      sum = {1'b0, cnt_type'(base)} + {1'b0, off};
      if (sum >= (CNT_W+1)'(STORE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(STORE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   always_comb begin
      case (cmd.rd_sel)
         RD_FRONT:    rd_off = cnt_type'(0);
         RD_ADDR:     rd_off = cnt_type'(1);
         RD_ID:       rd_off = cnt_type'(2);
         RD_LEN:      rd_off = cnt_type'(3);
         RD_PAY0:     rd_off = cnt_type'(PAY_OFFSET);
         RD_SUM_NEXT: rd_off = cnt_ff + cnt_type'(1);
         RD_PAY_NEXT: rd_off = cnt_ff + cnt_type'(PAY_OFFSET + 1);
         RD_SUM_CHK:  rd_off = len_ff + cnt_type'(PAY_OFFSET);
         RD_ADD_CHK:  rd_off = len_ff + cnt_type'(PAY_OFFSET + 1);
         default:     rd_off = cnt_type'(0);
      endcase
   end

   assign full     = (fill_ff == cnt_type'(STORE_DEPTH));
   assign rd_addr  = wrap(head_ff, rd_off);
   assign wr_addr  = wrap(head_ff, full ? cnt_type'(0) : fill_ff);
   assign drop_cnt = cmd.drop_one ? cnt_type'(1) : len_ff + cnt_type'(MIN_FRAME);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_mem[wr_addr] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      head_in        = head_ff;
      fill_in        = fill_ff;
      front_valid_in = front_valid_ff;
      if (cmd.accept) begin
         if (full) begin
            // oldest byte gives way
            head_in        = wrap(head_ff, cnt_type'(1));
            front_valid_in = 1'b0;
         end else begin
            fill_in = fill_ff + cnt_type'(1);
         end
      end else if (cmd.drop_one || cmd.drop_frame) begin
         head_in        = wrap(head_ff, drop_cnt);
         fill_in        = fill_ff - drop_cnt;
         front_valid_in = 1'b0;
      end else if (cmd.front_mark) begin
         front_valid_in = 1'b1;
      end
      if (csr_write) begin
         front_valid_in = 1'b0;
      end
   end

   assign running_sum_in = running_sum_ff + rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff      <= HEADER_RESET;
         address_ff     <= ADDRESS_RESET;
         head_ff        <= '0;
         fill_ff        <= '0;
         front_valid_ff <= 1'b0;
         running_sum_ff <= '0;
         running_add_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         head_ff        <= head_in;
         fill_ff        <= fill_in;
         front_valid_ff <= front_valid_in;
         if (csr_write && csr_index == CSR_HEADER_BYTE) begin
            header_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_MATCH_ADDRESS) begin
            address_ff <= csr_data;
         end
         if (cmd.acc_clear) begin
            running_sum_ff <= '0;
            running_add_ff <= '0;
         end else if (cmd.acc_en) begin
            running_sum_ff <= running_sum_in;
            running_add_ff <= running_add_ff + running_sum_in;
         end
         if (cmd.out_pay || cmd.out_mark) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.id_load) begin
         id_ff <= rd_data_ff;
      end
      if (cmd.len_load) begin
         len_ff <= rd_data_ff[CNT_W-1:0];
      end
      if (cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + cnt_type'(1);
      end
      if (cmd.out_pay) begin
         frame_id_ff       <= id_ff;
         payload_length_ff <= LEN_W'(len_ff);
         payload_byte_ff   <= rd_data_ff;
         byte_index_ff     <= cnt_ff[IDX_W-1:0];
         last_ff           <= sts.pay_last;
      end else if (cmd.out_mark) begin
         frame_id_ff       <= id_ff;
         payload_length_ff <= '0;
         payload_byte_ff   <= '0;
         byte_index_ff     <= '0;
         last_ff           <= 1'b1;
      end
   end

   always_comb begin
      sts.fill_zero   = (fill_ff == '0);
      sts.fill_short  = (fill_ff < cnt_type'(MIN_FRAME));
      sts.fill_full   = full;
      sts.front_valid = front_valid_ff;
      sts.is_header   = (rd_data_ff == header_ff);
      sts.addr_ok     = (rd_data_ff == address_ff);
      sts.len_ok      = (rd_data_ff <= BYTE_W'(MAX_PAYLOAD));
      sts.short_rd    = ({1'b0, fill_ff} <
                         {1'b0, rd_data_ff[CNT_W-1:0]} + (CNT_W+1)'(MIN_FRAME));
      sts.short_len   = ({1'b0, fill_ff} < {1'b0, len_ff} + (CNT_W+1)'(MIN_FRAME));
      sts.sum_done    = (cnt_ff == len_ff + cnt_type'(PAY_OFFSET - 1));
      sts.sum_ok      = (rd_data_ff == running_sum_ff);
      sts.add_ok      = (rd_data_ff == running_add_ff);
      sts.len_zero    = (len_ff == '0);
      sts.pay_last    = (cnt_ff + cnt_type'(1) == len_ff);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign frame_id       = frame_id_ff;
   assign payload_length = payload_length_ff;
   assign payload_byte   = payload_byte_ff;
   assign byte_index     = byte_index_ff;
   assign last           = last_ff;

endmodule

### design/checked_frame_deframer.sv
// byte in: a fill compare while a validated frame fills, else header, address and length
// checks and one read per byte skipped in a resync; a complete frame adds check sum reads
// on the single store read port, then one result per cycle unless the output stalls
// results leave via an output register, so input is taken while a frame's last one waits
// reset (synchronous, active high) empties the store and restores both registers
module checked_frame_deframer import cfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,    // rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // frame_id, payload_length, payload_byte,
                                               // byte_index, zero fill
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_idx_type           csr_index,
   input  logic [BYTE_W-1:0]     csr_data
);

   cmd_type           cmd;
   sts_type           sts;
   logic [BYTE_W-1:0] frame_id, payload_byte;
   logic [LEN_W-1:0]  payload_length;
   logic [IDX_W-1:0]  byte_index;

   assign csr_ready = 1'b1;

   cfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cfd_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .rx_byte        (req_tdata),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .frame_id       (frame_id),
      .payload_length (payload_length),
      .payload_byte   (payload_byte),
      .byte_index     (byte_index),
      .last           (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_FIELD_W)'(0), byte_index, payload_byte,
                       payload_length, frame_id};

   // an empty frame shows only as its single marker
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && payload_length == '0 |-> rsp_tlast && payload_byte == '0 &&
      byte_index == '0)
      else $error("empty frame marker malformed");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && payload_length != '0 |->
      {1'b0, byte_index} + LEN_W'(1) == payload_length)
      else $error("last mark not on final payload byte");

   a_mid_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> {1'b0, byte_index} + LEN_W'(1) < payload_length)
      else $error("payload index beyond frame length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> payload_length <= LEN_W'(MAX_PAYLOAD))
      else $error("payload length above limit");

endmodule

### tb/checked_frame_deframer_tb.sv
// testbench for checked_frame_deframer: directed frame table, then random frame traffic
// over several header and address settings, every result word checked against a predictor
// depends on cfd_pkg and the checked_frame_deframer rtl
module checked_frame_deframer_tb;
   import cfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 2000;     // longest rescan of a full store, with margin
   localparam int HOLD_AT       = 30;       // result word count at which the long hold starts
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_BYTES   = 65;
   localparam int TIMEOUT_NS    = 4_000_000;

   typedef struct packed {
      logic [7:0] frame_id;
      logic [5:0] payload_length;
      logic [7:0] payload_byte;
      logic [4:0] byte_index;
      logic       last;
   } payload_word_type;

   typedef enum {FL_NONE, FL_ADDR, FL_SUM, FL_ADD, FL_CUT} flaw_type;
   typedef enum {CHK_MODEL, CHK_MARK, CHK_NONE} check_type;

   typedef struct {
      logic [7:0] id;
      int         len;
      logic [7:0] base;
      logic [7:0] step;
      flaw_type   flaw;
      check_type  chk;
   } frame_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_idx_type           csr_index = CSR_HEADER_BYTE;
   logic [BYTE_W-1:0]     csr_data = '0;

   // predictor state
   logic [7:0]       cur_header = HEADER_RESET;
   logic [7:0]       cur_address = ADDRESS_RESET;
   logic [7:0]       held_bytes [STORE_DEPTH];
   int               held_count = 0;
   payload_word_type fresh_words [$];
   payload_word_type pending_words [$];
   logic [7:0]       frame_bytes [$];

   bit tx_burst = 1'b0;
   bit typed_row = 1'b0;
   bit held_off = 1'b0;
   int rx_sent = 0;
   int frames_built = 0;
   int words_checked = 0;
   int settings_used = 1;
   int mismatches = 0;

   // reset settings: empty frame, overlong length, extreme bytes, bad address,
   // bad sum check, bad add check, cut frame, header value inside the payload
   frame_row_type directed_rows [0:8] = '{
      '{8'h5A, 0,  8'h00, 8'h00, FL_NONE, CHK_MARK},
      '{8'h07, 33, 8'h00, 8'h00, FL_NONE, CHK_NONE},
      '{8'h00, 1,  8'h00, 8'h00, FL_NONE, CHK_MODEL},
      '{8'hFF, 4,  8'hFF, 8'h00, FL_NONE, CHK_MODEL},
      '{8'h21, 2,  8'h10, 8'h01, FL_ADDR, CHK_MODEL},
      '{8'h22, 2,  8'h20, 8'h01, FL_SUM,  CHK_MODEL},
      '{8'h23, 1,  8'h30, 8'h01, FL_ADD,  CHK_MODEL},
      '{8'h24, 3,  8'h40, 8'h01, FL_CUT,  CHK_MODEL},
      '{8'h25, 2,  8'hAA, 8'h55, FL_NONE, CHK_MODEL}
   };

   checked_frame_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic void drop_held(input int n);
      int k;
      if (n >= held_count) begin
         held_count = 0;
      end else begin
         for (k = 0; k < held_count - n; k++) held_bytes[k] = held_bytes[k + n];
         held_count -= n;
      end
   endfunction

   // one received byte into the store, then hunt and decide frames until stuck
   function automatic void deframe_byte(input logic [7:0] rx);
      int pos;
      int plen;
      int total;
      int k;
      logic [7:0] s;
      logic [7:0] a;
      bit busy;
      payload_word_type w;
      if (held_count >= STORE_DEPTH) drop_held(1);
      held_bytes[held_count] = rx;
      held_count++;
      busy = 1'b1;
      while (busy) begin
         pos = 0;
         while (pos < held_count && held_bytes[pos] != cur_header) pos++;
         drop_held(pos);
         if (held_count < MIN_FRAME) begin
            busy = 1'b0;
         end else if (held_bytes[1] != cur_address || held_bytes[3] > MAX_PAYLOAD) begin
            drop_held(1);
         end else begin
            plen = held_bytes[3];
            total = plen + MIN_FRAME;
            if (held_count < total) begin
               busy = 1'b0;
            end else begin
               s = '0;
               a = '0;
               for (k = 0; k < plen + PAY_OFFSET; k++) begin
                  s = s + held_bytes[k];
                  a = a + s;
               end
               if (held_bytes[plen + PAY_OFFSET] != s ||
                   held_bytes[plen + PAY_OFFSET + 1] != a) begin
                  drop_held(1);
               end else begin
                  w.frame_id = held_bytes[2];
                  if (plen == 0) begin
                     w.payload_length = '0;
                     w.payload_byte = '0;
                     w.byte_index = '0;
                     w.last = 1'b1;
                     fresh_words.insert(fresh_words.size(), w);
                  end else begin
                     for (k = 0; k < plen; k++) begin
                        w.payload_length = 6'(plen);
                        w.payload_byte = held_bytes[PAY_OFFSET + k];
                        w.byte_index = 5'(k);
                        w.last = (k == plen - 1);
                        fresh_words.insert(fresh_words.size(), w);
                     end
                  end
                  drop_held(total);
               end
            end
         end
      end
   endfunction

   // builds one frame under the current settings; an overlong length sends only
   // the two check bytes after the length byte
   function automatic void build_frame(input logic [7:0] id, input int len,
                                       input logic [7:0] base, input logic [7:0] step,
                                       input bit rnd, input flaw_type flaw);
      logic [7:0] s;
      logic [7:0] a;
      int n;
      int k;
      int cut;
      frame_bytes.delete();
      frame_bytes.insert(frame_bytes.size(), cur_header);
      if (flaw == FL_ADDR)
         frame_bytes.insert(frame_bytes.size(), cur_address ^ 8'($urandom_range(1, 255)));
      else
         frame_bytes.insert(frame_bytes.size(), cur_address);
      frame_bytes.insert(frame_bytes.size(), id);
      frame_bytes.insert(frame_bytes.size(), 8'(len));
      n = (len > MAX_PAYLOAD) ? 0 : len;
      for (k = 0; k < n; k++) begin
         if (rnd) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
         else frame_bytes.insert(frame_bytes.size(), base + 8'(step * k));
      end
      s = '0;
      a = '0;
      foreach (frame_bytes[i]) begin
         s = s + frame_bytes[i];
         a = a + s;
      end
      if (flaw == FL_SUM) s ^= 8'($urandom_range(1, 255));
      if (flaw == FL_ADD) a ^= 8'($urandom_range(1, 255));
      frame_bytes.insert(frame_bytes.size(), s);
      frame_bytes.insert(frame_bytes.size(), a);
      if (flaw == FL_CUT) begin
         cut = $urandom_range(1, n + 2);
         repeat (cut) void'(frame_bytes.pop_back());
      end
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      payload_word_type w;
      gap = tx_burst ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      do @(posedge clock); while (!req_tready);
      deframe_byte(b);
      // typed rows keep the predictor in step but bring their own expectation
      while (fresh_words.size() != 0) begin
         w = fresh_words.pop_front();
         if (!typed_row) pending_words.insert(pending_words.size(), w);
      end
      rx_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_frame();
      frames_built++;
      tx_burst = ($urandom_range(0, 3) == 0);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [7:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_HEADER_BYTE) cur_header = value;
      else cur_address = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic settle();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_match(input logic [7:0] header, input logic [7:0] address);
      settle();
      csr_write(CSR_HEADER_BYTE, header);
      csr_write(CSR_MATCH_ADDRESS, address);
      settings_used++;
   endtask

   // mostly good frames with random content, some noise and broken frames
   task automatic random_traffic(input int quota);
      int start;
      int pick;
      int len;
      flaw_type flaw;
      bit first;
      start = rx_sent;
      first = 1'b1;
      while (rx_sent - start < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            tx_burst = ($urandom_range(0, 1) == 0);
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            flaw = FL_NONE;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                               : $urandom_range(0, 6);
            if (first) begin
               len = MAX_PAYLOAD;
            end else if (pick >= 70) begin
               case ($urandom_range(0, 4))
                  0: flaw = FL_ADDR;
                  1: flaw = FL_SUM;
                  2: flaw = FL_ADD;
                  3: flaw = FL_CUT;
                  default: begin
                     len = ($urandom_range(0, 2) == 0) ? MAX_PAYLOAD + 1
                                                       : $urandom_range(MAX_PAYLOAD + 2, 255);
                  end
               endcase
            end
            first = 1'b0;
            build_frame(8'($urandom), len, 8'h00, 8'h00, 1'b1, flaw);
            send_frame();
         end
      end
   endtask

   // result side: random stalls, one long hold so the store backs up
   initial begin : result_drain
      int stall;
      bit rx_burst;
      payload_word_type want;
      rx_burst = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 13);
         if (words_checked == HOLD_AT && !held_off) begin
            held_off = 1'b1;
            stall = HOLD_CYCLES;
         end
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         words_checked++;
         if (pending_words.size() == 0) begin
            report_mismatch("result word with nothing pending", rsp_tdata, 0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata[7:0] != want.frame_id)
               report_mismatch("frame_id", rsp_tdata[7:0], want.frame_id);
            if (rsp_tdata[13:8] != want.payload_length)
               report_mismatch("payload_length", rsp_tdata[13:8], want.payload_length);
            if (rsp_tdata[21:14] != want.payload_byte)
               report_mismatch("payload_byte", rsp_tdata[21:14], want.payload_byte);
            if (rsp_tdata[26:22] != want.byte_index)
               report_mismatch("byte_index", rsp_tdata[26:22], want.byte_index);
            if (rsp_tlast != want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      payload_word_type mark;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         build_frame(directed_rows[i].id, directed_rows[i].len, directed_rows[i].base,
                     directed_rows[i].step, 1'b0, directed_rows[i].flaw);
         typed_row = (directed_rows[i].chk != CHK_MODEL);
         if (directed_rows[i].chk == CHK_MARK) begin
            mark.frame_id = directed_rows[i].id;
            mark.payload_length = '0;
            mark.payload_byte = '0;
            mark.byte_index = '0;
            mark.last = 1'b1;
            pending_words.insert(pending_words.size(), mark);
         end
         send_frame();
         typed_row = 1'b0;
      end

      random_traffic(PHASE_BYTES);
      set_match(8'h00, 8'h00);
      random_traffic(PHASE_BYTES);
      set_match(8'hFF, 8'hFF);
      random_traffic(PHASE_BYTES);
      set_match(8'($urandom), 8'($urandom));
      random_traffic(PHASE_BYTES);

      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d bytes in %0d frames under %0d header/address settings",
               rx_sent, frames_built, settings_used);
      $display("checked %0d result words, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
